// ===== design/diff_drive_odometry_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the differential-drive odometry core
// Shared property wrappers, clocked on i_clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef DIFF_DRIVE_ODOMETRY_CORE_MACROS_SVH
`define DIFF_DRIVE_ODOMETRY_CORE_MACROS_SVH

// Same-cycle implication
`define DDO_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("odometry check failed");

// Next-cycle implication
`define DDO_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("odometry check failed");

`endif

// ===== design/ddo_pkg.sv =====
// ---------------------------------------------------------------------------
// Odometry package
// Constants, command types and helper functions shared by the odometry core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ddo_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int DIV_STEPS         = 60;
    localparam int MUL_SPLIT         = 20;
    localparam int CNT_W             = $clog2(DIV_STEPS);

    localparam int PI_Q16      = 205887;
    localparam int WRAP_MOD    = 2 * PI_Q16;
    localparam int HALF_PI_Q16 = PI_Q16 / 2;
    localparam int KINV_Q16    = 39797;
    localparam int USEC_PER_S  = 1000000;

    // reciprocal of two pi for the turn reduction, quotient = (x * recip) >> shift
    localparam int          MOD_SHIFT = 42;
    localparam logic [23:0] MOD_RECIP = 24'((64'd1 << MOD_SHIFT) / 64'(WRAP_MOD));

    localparam logic [23:0] MPC_RESET = 24'd65536;
    localparam logic [23:0] IWB_RESET = 24'd83886;

    // configuration register indexes
    localparam logic REG_MPC = 1'b0;
    localparam logic REG_IWB = 1'b1;

    // multiplier phases
    localparam logic [1:0] PH_HI  = 2'd0;
    localparam logic [1:0] PH_LO  = 2'd1;
    localparam logic [1:0] PH_SUM = 2'd2;

    typedef enum logic [3:0] {
        MP_SUM  = 4'd0,
        MP_DIFF = 4'd1,
        MP_TURN = 4'd2,
        MP_MODQ = 4'd3,
        MP_MODP = 4'd4,
        MP_SPD  = 4'd5,
        MP_RATE = 4'd6,
        MP_DX   = 4'd7,
        MP_DY   = 4'd8
    } t_mul_pair;

    typedef struct packed {
        logic      load;
        logic      mul_en;
        t_mul_pair mul_pair;
        logic [1:0] mul_ph;
        logic      div_step;
        logic      angle;
        logic      cordic_step;
        logic [4:0] cordic_idx;
        logic      commit;
    } t_dp_cmd;

    localparam logic [31:0] ATAN_Q30 [24] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128
    };

    // arctangent of 2^-idx, rounded to Q.16
    function automatic logic signed [19:0] atan_q16(input logic [4:0] idx);
        logic [32:0] t;
        t = 33'd0;
        if (idx < 5'd24) begin
            t = 33'(ATAN_Q30[idx]) + 33'd8192;
        end
        return $signed(20'(t >> 14));
    endfunction

    // clamp to 32-bit signed
    function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
        if (v > 44'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -44'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // signed magnitude to 32-bit signed, clamped
    function automatic logic [31:0] sat_mag(input logic [59:0] q, input logic neg);
        if (neg) begin
            if (q > 60'd2147483648) begin
                return 32'h80000000;
            end
            return 32'(-q);
        end
        if (q > 60'd2147483647) begin
            return 32'h7fffffff;
        end
        return q[31:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/ddo_ctrl.sv =====
// ---------------------------------------------------------------------------
// Odometry controller
// Sequences multiplies, serial divide, CORDIC and the pose update.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ddo_ctrl import ddo_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_MULA, S_DIV, S_ANGLE, S_CORDIC, S_MULB, S_WAIT
    } t_state;

    t_state          r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    t_mul_pair       r_pair, n_pair;
    logic [1:0]      r_ph, n_ph;
    logic            r_out_valid, n_out_valid;
    logic            commit;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign commit  = (r_state == S_WAIT) && (!r_out_valid || i_ready);

    // decode datapath commands
    always_comb begin
        o_cmd             = '0;
        o_cmd.load        = o_ready && i_valid;
        o_cmd.mul_en      = (r_state == S_MULA) || (r_state == S_MULB);
        o_cmd.mul_pair    = r_pair;
        o_cmd.mul_ph      = r_ph;
        o_cmd.div_step    = (r_state == S_DIV);
        o_cmd.angle       = (r_state == S_ANGLE);
        o_cmd.cordic_step = (r_state == S_CORDIC);
        o_cmd.cordic_idx  = r_cnt[4:0];
        o_cmd.commit      = commit;
    end

    // next state
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pair      = r_pair;
        n_ph        = r_ph;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_MULA;
                    n_pair  = MP_SUM;
                    n_ph    = PH_HI;
                end
            end
            S_MULA, S_MULB: begin
                if (r_ph == PH_SUM) begin
                    n_ph = PH_HI;
                    if (r_pair == MP_RATE) begin
                        n_state = S_DIV;
                        n_cnt   = '0;
                    end else if (r_pair == MP_DY) begin
                        n_state = S_WAIT;
                    end else begin
                        n_pair = t_mul_pair'(r_pair + 4'd1);
                    end
                end else begin
                    n_ph = r_ph + 2'd1;
                end
            end
            S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_ANGLE;
                end
            end
            S_ANGLE: begin
                n_state = S_CORDIC;
                n_cnt   = '0;
            end
            S_CORDIC: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CORDIC_ITERATIONS - 1)) begin
                    n_state = S_MULB;
                    n_pair  = MP_DX;
                    n_ph    = PH_HI;
                end
            end
            S_WAIT: begin
                if (commit) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_pair      <= MP_SUM;
            r_ph        <= PH_HI;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pair      <= n_pair;
            r_ph        <= n_ph;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// ===== design/ddo_datapath.sv =====
// ---------------------------------------------------------------------------
// Odometry datapath
// Shared multiplier, serial divider, turn reduction, CORDIC and pose registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ddo_datapath import ddo_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_dp_cmd            i_cmd,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [23:0]        i_cfg_data,
    input  wire logic signed [15:0] i_left_delta,
    input  wire logic signed [15:0] i_right_delta,
    input  wire logic [19:0]        i_elapsed_us,
    output logic signed [31:0]      o_pos_x,
    output logic signed [31:0]      o_pos_y,
    output logic signed [18:0]      o_heading,
    output logic signed [31:0]      o_linear_speed,
    output logic signed [31:0]      o_turn_rate
);

    logic [23:0]        r_mpc, r_iwb;
    logic signed [31:0] r_x, r_y;
    logic signed [18:0] r_head, r_head_new;
    logic               r_sneg, r_dneg, r_fold;
    logic [16:0]        r_smag;
    logic [15:0]        r_dmag;
    logic [19:0]        r_el;
    logic [40:0]        r_p;
    logic [39:0]        r_dmm, r_a16m;
    logic [63-MOD_SHIFT:0] r_modq;
    logic [19:0]        r_modp;
    logic [47:0]        r_prod;
    logic [63:0]        r_acc;
    logic [59:0]        r_qs, r_qr;
    logic [19:0]        r_rem_s, r_rem_r;
    logic [18:0]        r_mrem, r_mhalf;
    logic [40:0]        r_dxm, r_dym;
    logic signed [19:0] r_cx, r_cy, r_z;
    logic signed [31:0] r_out_x, r_out_y, r_out_spd, r_out_rate;
    logic signed [18:0] r_out_head;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mpc <= MPC_RESET;
            r_iwb <= IWB_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MPC: r_mpc <= i_cfg_data;
                REG_IWB: r_iwb <= i_cfg_data;
                default: r_iwb <= r_iwb;
            endcase
        end
    end

    // request capture: sum and difference magnitudes
    logic signed [16:0] sum_s, diff_s;
    assign sum_s  = 17'(i_left_delta) + 17'(i_right_delta);
    assign diff_s = 17'(i_right_delta) - 17'(i_left_delta);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sneg <= sum_s[16];
            r_dneg <= diff_s[16];
            r_smag <= sum_s[16] ? 17'(-sum_s) : 17'(sum_s);
            r_dmag <= diff_s[16] ? 16'(-diff_s) : 16'(diff_s);
            r_el   <= i_elapsed_us;
        end
    end

    // shared multiplier operands
    logic [19:0] cx_abs, cy_abs;
    logic [43:0] mul_full;
    logic [23:0] mul_a, mul_b;
    logic [63:0] mul_sum;

    assign cx_abs = r_cx[19] ? 20'(-r_cx) : 20'(r_cx);
    assign cy_abs = r_cy[19] ? 20'(-r_cy) : 20'(r_cy);

    always_comb begin
        case (i_cmd.mul_pair)
            MP_SUM:  begin mul_full = 44'(r_smag);     mul_b = r_mpc;              end
            MP_DIFF: begin mul_full = 44'(r_dmag);     mul_b = r_mpc;              end
            MP_TURN: begin mul_full = 44'(r_dmm);      mul_b = r_iwb;              end
            MP_MODQ: begin mul_full = 44'(r_a16m);     mul_b = MOD_RECIP;          end
            MP_MODP: begin mul_full = 44'(r_modq);     mul_b = 24'(WRAP_MOD);      end
            MP_SPD:  begin mul_full = 44'(r_p);        mul_b = 24'(USEC_PER_S);    end
            MP_RATE: begin mul_full = 44'(r_a16m);     mul_b = 24'(USEC_PER_S);    end
            MP_DX:   begin mul_full = 44'(r_p[40:1]);  mul_b = 24'(cx_abs);        end
            MP_DY:   begin mul_full = 44'(r_p[40:1]);  mul_b = 24'(cy_abs);        end
            default: begin mul_full = '0;              mul_b = '0;                 end
        endcase
        mul_a = (i_cmd.mul_ph == PH_HI) ? mul_full[43:MUL_SPLIT]
                                        : 24'(mul_full[MUL_SPLIT-1:0]);
    end

    assign mul_sum = r_acc + 64'(r_prod);

    // multiply high part, then low part, then combine and store
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= mul_a * mul_b;
            if (i_cmd.mul_ph == PH_LO) begin
                r_acc <= 64'({r_prod, {MUL_SPLIT{1'b0}}});
            end
            if (i_cmd.mul_ph == PH_SUM) begin
                case (i_cmd.mul_pair)
                    MP_SUM:  r_p    <= mul_sum[40:0];
                    MP_DIFF: r_dmm  <= mul_sum[39:0];
                    MP_TURN: r_a16m <= mul_sum[63:24];
                    MP_MODQ: r_modq <= mul_sum[63:MOD_SHIFT];
                    MP_MODP: r_modp <= mul_sum[19:0];
                    MP_DX:   r_dxm  <= mul_sum[56:16];
                    MP_DY:   r_dym  <= mul_sum[56:16];
                    default: r_dym  <= r_dym;
                endcase
            end
        end
    end

    // restoring division of both rates by the period, one bit a cycle
    logic [20:0] ts, tr;
    logic        ges, ger;
    assign ts  = {r_rem_s, r_qs[59]};
    assign tr  = {r_rem_r, r_qr[59]};
    assign ges = ts >= {1'b0, r_el};
    assign ger = tr >= {1'b0, r_el};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem_s <= '0;
            r_rem_r <= '0;
        end else if (i_cmd.div_step) begin
            r_rem_s <= ges ? 20'(ts - 21'(r_el)) : ts[19:0];
            r_rem_r <= ger ? 20'(tr - 21'(r_el)) : tr[19:0];
            r_qs    <= {r_qs[58:0], ges};
            r_qr    <= {r_qr[58:0], ger};
        end
        // load dividends from the multiplier
        if (i_cmd.mul_en && (i_cmd.mul_ph == PH_SUM)) begin
            if (i_cmd.mul_pair == MP_SPD) begin
                r_qs <= 60'(mul_sum[60:9]);
            end
            if (i_cmd.mul_pair == MP_RATE) begin
                r_qr <= mul_sum[59:0];
            end
        end
    end

    // turn modulo two pi: estimated quotient leaves a remainder below
    // twice the modulus, so one compare and subtract finishes it; the half
    // turn remainder follows from the quotient parity
    logic [19:0] mrem0, mrem1;
    logic        mge, modd;
    assign mrem0 = r_a16m[19:0] - r_modp;
    assign mge   = mrem0 >= 20'(WRAP_MOD);
    assign mrem1 = mge ? (mrem0 - 20'(WRAP_MOD)) : mrem0;
    assign modd  = r_modq[0] ^ mge;

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_step) begin
            r_mrem  <= mrem1[18:0];
            r_mhalf <= (modd ? 19'(PI_Q16) : 19'd0) + mrem1[19:1];
        end
    end

    // new heading and wrapped midpoint angle
    logic signed [21:0] hp, dh, w1, w1c, half_t, dm, w2, w2c, mid, midf;
    logic               fold;
    always_comb begin
        hp     = 22'(r_head) + 22'sd205887;
        dh     = r_dneg ? -$signed({3'b000, r_mrem}) : $signed({3'b000, r_mrem});
        w1     = hp + dh;
        w1c    = w1;
        if (w1 < 22'sd0) begin
            w1c = w1 + 22'(WRAP_MOD);
        end else if (w1 >= 22'(WRAP_MOD)) begin
            w1c = w1 - 22'(WRAP_MOD);
        end
        half_t = $signed({3'b000, r_mhalf}) + $signed({21'd0, r_a16m[0]});
        dm     = r_dneg ? -half_t : $signed({3'b000, r_mhalf});
        w2     = hp + dm;
        w2c    = w2;
        if (w2 < 22'sd0) begin
            w2c = w2 + 22'(WRAP_MOD);
        end else if (w2 >= 22'(WRAP_MOD)) begin
            w2c = w2 - 22'(WRAP_MOD);
        end
        mid  = w2c - 22'(PI_Q16);
        midf = mid;
        fold = 1'b0;
        if (mid > 22'(HALF_PI_Q16)) begin
            midf = mid - 22'(PI_Q16);
            fold = 1'b1;
        end else if (mid < -22'(HALF_PI_Q16)) begin
            midf = mid + 22'(PI_Q16);
            fold = 1'b1;
        end
    end

    // CORDIC rotation, one micro-rotation a cycle
    logic signed [19:0] tx, ty, at;
    assign tx = r_cy >>> i_cmd.cordic_idx;
    assign ty = r_cx >>> i_cmd.cordic_idx;
    assign at = atan_q16(i_cmd.cordic_idx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.angle) begin
            r_head_new <= 19'(w1c - 22'(PI_Q16));
            r_z        <= 20'(midf);
            r_fold     <= fold;
            r_cx       <= 20'(KINV_Q16);
            r_cy       <= '0;
        end else if (i_cmd.cordic_step) begin
            if (!r_z[19]) begin
                r_cx <= r_cx - tx;
                r_cy <= r_cy + ty;
                r_z  <= r_z - at;
            end else begin
                r_cx <= r_cx + tx;
                r_cy <= r_cy - ty;
                r_z  <= r_z + at;
            end
        end
    end

    // pose update and result capture
    logic               xneg, yneg;
    logic signed [42:0] dxs, dys;
    logic signed [31:0] nx, ny;
    assign xneg = r_sneg ^ r_cx[19] ^ r_fold;
    assign yneg = r_sneg ^ r_cy[19] ^ r_fold;
    assign dxs  = xneg ? -$signed({2'b00, r_dxm}) : $signed({2'b00, r_dxm});
    assign dys  = yneg ? -$signed({2'b00, r_dym}) : $signed({2'b00, r_dym});
    assign nx   = sat32(44'(r_x) + 44'(dxs));
    assign ny   = sat32(44'(r_y) + 44'(dys));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x    <= '0;
            r_y    <= '0;
            r_head <= '0;
        end else if (i_cmd.commit) begin
            r_x    <= nx;
            r_y    <= ny;
            r_head <= r_head_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_x    <= nx;
            r_out_y    <= ny;
            r_out_head <= r_head_new;
            r_out_spd  <= (r_el == '0) ? 32'sd0 : $signed(sat_mag(r_qs, r_sneg));
            r_out_rate <= (r_el == '0) ? 32'sd0 : $signed(sat_mag(r_qr, r_dneg));
        end
    end

    assign o_pos_x        = r_out_x;
    assign o_pos_y        = r_out_y;
    assign o_heading      = r_out_head;
    assign o_linear_speed = r_out_spd;
    assign o_turn_rate    = r_out_rate;

endmodule

`default_nettype wire

// ===== design/diff_drive_odometry_core.sv =====
// ---------------------------------------------------------------------------
// Differential-drive odometry core
// Midpoint dead reckoning of x, y and heading with speed and turn rate.
// ---------------------------------------------------------------------------
// A request runs through the first multiplies, the bit-serial divide, the angle step, the
//   CORDIC rotations, the second multiplies and the update before its result is valid.
// One request at a time: a new request is accepted only once the last one has committed.
// A finished result waits in the output register while the next request runs.
// Reset (synchronous, active low) clears the pose and restores both registers.
`timescale 1ns / 1ps
`default_nettype none

module diff_drive_odometry_core import ddo_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [23:0]        i_cfg_data,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [15:0] i_left_delta,
    input  wire logic signed [15:0] i_right_delta,
    input  wire logic [19:0]        i_elapsed_us,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_pos_x,
    output logic signed [31:0]      o_pos_y,
    output logic signed [18:0]      o_heading,
    output logic signed [31:0]      o_linear_speed,
    output logic signed [31:0]      o_turn_rate
);

    t_dp_cmd cmd;

    // sequence control
    ddo_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    // arithmetic and pose state
    ddo_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_left_delta   (i_left_delta),
        .i_right_delta  (i_right_delta),
        .i_elapsed_us   (i_elapsed_us),
        .o_pos_x        (o_pos_x),
        .o_pos_y        (o_pos_y),
        .o_heading      (o_heading),
        .o_linear_speed (o_linear_speed),
        .o_turn_rate    (o_turn_rate)
    );

endmodule

`default_nettype wire

// ===== design/ddo_checker.sv =====
// ---------------------------------------------------------------------------
// Odometry port checker
// Watches the top-level ports of the odometry core over time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "diff_drive_odometry_core_macros.svh"

module ddo_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_ready,
    input wire logic               o_valid,
    input wire logic               i_ready,
    input wire logic signed [31:0] o_pos_x,
    input wire logic signed [31:0] o_pos_y,
    input wire logic signed [18:0] o_heading
);

    // a stalled result holds
    `DDO_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid)
    `DDO_ASSERT_NEXT(a_out_stable, o_valid && !i_ready,
                     $stable(o_pos_x) && $stable(o_pos_y) && $stable(o_heading))
    // one request in flight: busy after accept
    `DDO_ASSERT_NEXT(a_busy_after_accept, i_valid && o_ready, !o_ready)
    // reported heading stays wrapped
    `DDO_ASSERT_NOW(a_heading_range, o_valid,
                    (o_heading >= -19'sd205887) && (o_heading <= 19'sd205886))

endmodule

bind diff_drive_odometry_core ddo_checker u_chk (.*);

`default_nettype wire
